// ===== src/p1305_pkg.sv =====
// Shared constants and types for the Poly1305 tag core.
// No dependencies; imported by poly1305_mac_tag_core.
`timescale 1ns / 1ps
`default_nettype none

package p1305_pkg;

  localparam int LIMB_W    = 26;   // radix-2^26 limbs
  localparam int NUM_LIMBS = 5;
  localparam int ACC_W     = 130;  // accumulator, kept below 2^130
  localparam int SUM_W     = ACC_W + 1;
  localparam int MSG_W     = 129;  // 16 data bytes plus pad bit
  localparam int HL_W      = LIMB_W + 1;   // top limb of acc + msg is 27 bits
  localparam int OP_W      = LIMB_W + 3;   // 5 * r limb
  localparam int PROD_W    = HL_W + OP_W;
  localparam int ROW_W     = PROD_W + 3;   // five products summed
  localparam int T_W       = ROW_W + LIMB_W * (NUM_LIMBS - 1) + 1;
  localparam int HI_W      = T_W - ACC_W;
  localparam int FIVE_W    = HI_W + 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [63:0] CLAMP_LOW  = 64'h0ffffffc0fffffff;
  localparam logic [63:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;
  localparam logic [4:0]  FULL_BLOCK = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R_KEY_LOW  = 2'd0,
    REG_R_KEY_HIGH = 2'd1,
    REG_S_KEY_LOW  = 2'd2,
    REG_S_KEY_HIGH = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/poly1305_mac_tag_core.sv =====
// Poly1305 tag core: key registers, block absorb, modular multiply, tag output.
// Depends on p1305_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Poly1305 one-time authenticator. Load the 32-byte key through the write port
// (r is clamped internally, s is added at the end), then send one 16-byte block
// per input word with its byte count and a last flag; the 128-bit tag comes out
// after the last block and the accumulator is cleared for the next message.
// A block is absorbed in steps before in_ready returns: the padded block is added,
// then the row multiplier runs (five rows of five 27x29-bit products, one limb of
// the result per cycle, plus the final column add), then two carry folds mod
// 2^130-5. A last block adds final reduction and s addition; a last word with
// count 0 goes straight to them. A word with count 0 and last clear is taken and
// dropped. The tag sits in an output register, so the next message may start
// while it waits.
module poly1305_mac_tag_core
  import p1305_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [63:0]          block_low,
  input  wire logic [63:0]          block_high,
  input  wire logic [4:0]           byte_count,
  input  wire logic                 last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               tag_low,
  output logic [63:0]               tag_high
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FOLD1,
    S_FOLD2,
    S_FIN1,
    S_FIN2
  } state_t;

  state_t state;
  logic [2:0] cnt;

  logic [63:0] r_key_low, r_key_high, s_key_low, s_key_high;
  logic [ACC_W-1:0] acc;
  logic [SUM_W-1:0] hsum;
  logic [LIMB_W-1:0] r_limb [NUM_LIMBS];
  logic [OP_W-1:0] r5_limb [1:NUM_LIMBS-1];
  logic [ROW_W-1:0] row;
  logic [T_W-1:0] tacc;
  logic [SUM_W-1:0] fold1;
  logic [127:0] hsel;
  logic last_q;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r_key_low  <= '0;
      r_key_high <= '0;
      s_key_low  <= '0;
      s_key_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_R_KEY_LOW:  r_key_low  <= cfg_data;
        REG_R_KEY_HIGH: r_key_high <= cfg_data;
        REG_S_KEY_LOW:  s_key_low  <= cfg_data;
        REG_S_KEY_HIGH: s_key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // padded message block: bytes past the count are zero, 0x01 follows them
  logic [4:0]       n_sat;
  logic [127:0]     blk;
  logic [127:0]     msg_data;
  logic [MSG_W-1:0] pad;
  logic [MSG_W-1:0] msg;
  logic [SUM_W-1:0] hsum_next;
  logic [127:0]     r_clamped;

  always_comb begin
    n_sat = (byte_count > FULL_BLOCK) ? FULL_BLOCK : byte_count;
    blk   = {block_high, block_low};
    for (int b = 0; b < 16; b++) begin
      msg_data[8*b +: 8] = (5'(b) < n_sat) ? blk[8*b +: 8] : 8'h00;
    end
    pad       = MSG_W'(1) << {n_sat, 3'b000};
    msg       = {1'b0, msg_data} | pad;
    hsum_next = {1'b0, acc} + {2'b00, msg};
    r_clamped = {r_key_high & CLAMP_HIGH, r_key_low & CLAMP_LOW};
  end

  // one row of the limb product: t[ri] = sum_j h[j] * r[ri-j], wrapped terms x5
  logic [HL_W-1:0] hl [NUM_LIMBS];
  logic [2:0]      ri;
  logic [OP_W-1:0] op;
  logic [PROD_W-1:0] prod;
  logic [ROW_W-1:0] row_next;

  always_comb begin
    for (int j = 0; j < NUM_LIMBS - 1; j++) begin
      hl[j] = {1'b0, hsum[LIMB_W*j +: LIMB_W]};
    end
    hl[NUM_LIMBS-1] = hsum[SUM_W-1 : LIMB_W*(NUM_LIMBS-1)];
  end

  always_comb begin
    ri       = (cnt == 3'(NUM_LIMBS)) ? 3'd0 : cnt;
    row_next = '0;
    op       = '0;
    prod     = '0;
    for (int j = 0; j < NUM_LIMBS; j++) begin
      if (ri >= 3'(j)) begin
        op = {3'b000, r_limb[ri - 3'(j)]};
      end else begin
        op = r5_limb[ri + 3'(NUM_LIMBS - j)];
      end
      prod     = {{(PROD_W-HL_W){1'b0}}, hl[j]} * {{(PROD_W-OP_W){1'b0}}, op};
      row_next = row_next + ROW_W'(prod);
    end
  end

  // place the previous row at its limb position
  logic [T_W-1:0] row_sh;
  always_comb begin
    case (cnt)
      3'd1:    row_sh = T_W'(row);
      3'd2:    row_sh = T_W'(row) << LIMB_W;
      3'd3:    row_sh = T_W'(row) << (2 * LIMB_W);
      3'd4:    row_sh = T_W'(row) << (3 * LIMB_W);
      3'd5:    row_sh = T_W'(row) << (4 * LIMB_W);
      default: row_sh = '0;
    endcase
  end

  // folds mod 2^130-5 and final reduction
  logic [FIVE_W-1:0] five_hi;
  logic [SUM_W-1:0]  fold1_next;
  logic [ACC_W-1:0]  fold2_next;
  logic [SUM_W-1:0]  g;
  always_comb begin
    five_hi    = FIVE_W'({tacc[T_W-1:ACC_W], 2'b00}) + FIVE_W'(tacc[T_W-1:ACC_W]);
    fold1_next = {1'b0, tacc[ACC_W-1:0]} + SUM_W'(five_hi);
    fold2_next = fold1[ACC_W-1:0] + (fold1[ACC_W] ? ACC_W'(5) : '0);
    g          = {1'b0, acc} + SUM_W'(5);
  end

  logic tag_load;

  assign in_ready = (state == S_IDLE);
  // tag register is free or is being read this cycle
  assign tag_load = (state == S_FIN2) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (tag_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_q <= last;
            if (n_sat != 5'd0) begin
              hsum <= hsum_next;
              for (int k = 0; k < NUM_LIMBS; k++) begin
                r_limb[k] <= LIMB_W'({2'b00, r_clamped} >> (LIMB_W * k));
              end
              for (int k = 1; k < NUM_LIMBS; k++) begin
                r5_limb[k] <= {3'b000, LIMB_W'({2'b00, r_clamped} >> (LIMB_W * k))} +
                              {1'b0, LIMB_W'({2'b00, r_clamped} >> (LIMB_W * k)), 2'b00};
              end
              tacc  <= '0;
              cnt   <= '0;
              state <= S_MUL;
            end else if (last) begin
              state <= S_FIN1;
            end
          end
        end
        S_MUL: begin
          if (cnt < 3'(NUM_LIMBS)) begin
            row <= row_next;
          end
          if (cnt != 3'd0) begin
            tacc <= tacc + row_sh;
          end
          if (cnt == 3'(NUM_LIMBS)) begin
            state <= S_FOLD1;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_FOLD1: begin
          fold1 <= fold1_next;
          state <= S_FOLD2;
        end
        S_FOLD2: begin
          acc   <= fold2_next;
          state <= last_q ? S_FIN1 : S_IDLE;
        end
        S_FIN1: begin
          // acc < 2^130 < 2p, so one conditional subtract of p is enough
          hsel  <= g[ACC_W] ? g[127:0] : acc[127:0];
          state <= S_FIN2;
        end
        S_FIN2: begin
          if (tag_load) begin
            {tag_high, tag_low} <= hsel + {s_key_high, s_key_low};
            acc   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // first fold can only overflow 2^130 by a small amount
  a_fold_small: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD2 && fold1[ACC_W]) |-> (fold1[ACC_W-1:37] == '0))
    else $error("fold overflow leaves large low part");

  // a new tag always comes with a cleared accumulator
  a_tag_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (acc == '0))
    else $error("accumulator not cleared with tag");

  // a counted block starts the multiplier at row zero
  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && byte_count != 5'd0) |=> (state == S_MUL && cnt == 3'd0))
    else $error("block did not start multiply");

endmodule

`default_nettype wire
